### rtl/pmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_pkg
// Shared types and constants for the paged memory mapper with plane writes.
// ----------------------------------------------------------------------------
package pmm_pkg;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int OP_W = 3;
   localparam int KIND_W = 3;
   localparam int MODE_W = 4;
   localparam int REG_IDX_W = 4;

   localparam int WINDOW_COUNT_DEFAULT = 16;
   localparam int WINDOW_BITS_DEFAULT = 12;

   localparam logic [DATA_W-1:0] PAGE_RESET = 8'hFF;
   localparam logic [DATA_W-1:0] RAM_FIRST = 8'hE0;
   localparam logic [DATA_W-1:0] RAM_LAST = 8'hEF;
   localparam logic [DATA_W-1:0] ROM_FIRST = 8'hF8;
   localparam logic [DATA_W-1:0] PLANE_RED = 8'hE6;
   localparam logic [DATA_W-1:0] PLANE_GREEN = 8'hEA;
   localparam logic [DATA_W-1:0] PLANE_BLUE = 8'hEE;
   localparam logic [ADDR_W-1:0] PLANE_PART = 16'h1000;
   localparam logic [ADDR_W-1:0] BASE_RED = 16'h6000;
   localparam logic [ADDR_W-1:0] BASE_GREEN = 16'hA000;
   localparam logic [ADDR_W-1:0] BASE_BLUE = 16'hE000;
   localparam int COPY_BIT = 3;

   typedef enum logic [OP_W-1:0] {
      OP_CPU_READ   = 3'd0,
      OP_CPU_WRITE  = 3'd1,
      OP_PAGE_WRITE = 3'd2,
      OP_PAGE_READ  = 3'd3,
      OP_MODE_WRITE = 3'd4
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_RAM_READ  = 3'd0,
      KIND_ROM_READ  = 3'd1,
      KIND_RAM_WRITE = 3'd2,
      KIND_DROPPED   = 3'd3,
      KIND_UNMAPPED  = 3'd4,
      KIND_REG_DATA  = 3'd5,
      KIND_DONE      = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] target_address;
      logic [DATA_W-1:0] out_data;
      logic              last;
   } rsp_type;

endpackage

### rtl/paged_memory_mapper_with_plane_writes_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_memory_mapper_with_plane_writes_core
// Maps CPU accesses through a page register memory into RAM, ROM and video
// plane commands.
// ----------------------------------------------------------------------------
//  Channel   Ports                       Transfer
//  request   start, busy, req_word       taken when start is high, busy low
//  response  rsp_strobe, rsp_word        a word with each strobe, no back-pressure
//
//  After acceptance busy stays high through the lookup state and the emit of
//  n result words (1, or 3 for a copy-mode plane write): the lookup state
//  reads the page register memory, then one word leaves per cycle. A new word
//  is taken only in the idle state, once the last result word has left.
//  Reset makes every page register read as FF through per-entry valid bits, so
//  no clearing pass is needed; the block accepts a word as soon as reset is
//  released. The receiver cannot stall the result words.
module paged_memory_mapper_with_plane_writes_core #(
   parameter int WINDOW_COUNT = pmm_pkg::WINDOW_COUNT_DEFAULT,
   parameter int WINDOW_BITS = pmm_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pmm_pkg::req_type req_word,
   output logic             rsp_strobe,
   output pmm_pkg::rsp_type rsp_word
);
   import pmm_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_COUNT);
   localparam int WIN_W = ADDR_W - WINDOW_BITS;

   state_type state_ff, state_in;
   req_type req_ff;
   logic [1:0] beat_ff, beat_in;
   logic [MODE_W-1:0] mode_ff;
   logic [WINDOW_COUNT-1:0] valid_ff;
   logic [DATA_W-1:0] mem [WINDOW_COUNT];
   logic [DATA_W-1:0] rd_data_ff;
   logic rd_valid_ff;

   logic [WIN_W-1:0] win;
   logic win_ok, reg_ok, mem_we;
   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic [DATA_W-1:0] page;
   logic [ADDR_W-1:0] off, plane_addr, ram_addr, rom_addr, base;
   logic is_ram, is_rom, is_plane, copy;
   logic [1:0] plane, n_last;
   rsp_type rsp;

   assign win = req_ff.address[ADDR_W-1:WINDOW_BITS];
   assign win_ok = {1'b0, win} < (WIN_W + 1)'(WINDOW_COUNT);
   assign reg_ok = {1'b0, req_ff.address[REG_IDX_W-1:0]} < (REG_IDX_W + 1)'(WINDOW_COUNT);
   assign wr_idx = req_ff.address[IDX_W-1:0];
   assign rd_idx = (req_ff.operation == OP_PAGE_READ) ? wr_idx : win[IDX_W-1:0];
   assign mem_we = (state_ff == S_LOOKUP) && (req_ff.operation == OP_PAGE_WRITE) && reg_ok;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         beat_ff <= 2'd0;
         mode_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         beat_ff <= beat_in;
         if (state_ff == S_LOOKUP && req_ff.operation == OP_MODE_WRITE) begin
            mode_ff <= req_ff.write_data[MODE_W-1:0];
         end
         if (mem_we) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Payload and page register memory.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_word;
      end
      if (mem_we) begin
         mem[wr_idx] <= req_ff.write_data;
      end
      if (state_ff == S_LOOKUP) begin
         rd_data_ff <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      beat_in = beat_ff;
      case (state_ff)
         S_IDLE: begin
            beat_in = 2'd0;
            if (start) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            beat_in = beat_ff + 2'd1;
            if (rsp.last) begin
               state_in = S_IDLE;
               beat_in = 2'd0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result word for the current beat.
   always_comb begin
      page = rd_valid_ff ? rd_data_ff : PAGE_RESET;
      off = ADDR_W'(req_ff.address[WINDOW_BITS-1:0]);
      is_ram = (page >= RAM_FIRST) && (page <= RAM_LAST);
      is_rom = page >= ROM_FIRST;
      is_plane = is_ram && (page[DATA_W-1:1] == PLANE_RED[DATA_W-1:1]
         || page[DATA_W-1:1] == PLANE_GREEN[DATA_W-1:1]
         || page[DATA_W-1:1] == PLANE_BLUE[DATA_W-1:1]);
      copy = mode_ff[COPY_BIT];
      ram_addr = (ADDR_W'(page[3:0]) << WINDOW_BITS) + off;
      rom_addr = (ADDR_W'(page[2:0]) << WINDOW_BITS) + off;
      // Outside copy mode the three nibble bits above bit 0 pick the plane: 3 red, 5 green, 7 blue.
      plane = copy ? beat_ff : ((page[3:1] == PLANE_RED[3:1]) ? 2'd0
         : (page[3:1] == PLANE_GREEN[3:1]) ? 2'd1 : 2'd2);
      case (plane)
         2'd0: base = BASE_RED;
         2'd1: base = BASE_GREEN;
         default: base = BASE_BLUE;
      endcase
      plane_addr = base + off + (page[0] ? PLANE_PART : '0);
      n_last = 2'd0;
      rsp.kind = KIND_DONE;
      rsp.target_address = '0;
      rsp.out_data = '0;
      case (req_ff.operation)
         OP_CPU_READ, OP_CPU_WRITE: begin
            if (!win_ok) begin
               rsp.kind = KIND_UNMAPPED;
            end else if (is_ram) begin
               if (req_ff.operation == OP_CPU_READ) begin
                  rsp.kind = KIND_RAM_READ;
                  rsp.target_address = ram_addr;
               end else if (!is_plane) begin
                  rsp.kind = KIND_RAM_WRITE;
                  rsp.target_address = ram_addr;
                  rsp.out_data = req_ff.write_data;
               end else begin
                  rsp.kind = KIND_RAM_WRITE;
                  rsp.target_address = plane_addr;
                  if (copy) begin
                     n_last = 2'd2;
                     rsp.out_data = mode_ff[beat_ff] ? req_ff.write_data : '0;
                  end else begin
                     rsp.out_data = req_ff.write_data;
                  end
               end
            end else if (is_rom) begin
               if (req_ff.operation == OP_CPU_READ) begin
                  rsp.kind = KIND_ROM_READ;
                  rsp.target_address = rom_addr;
               end else begin
                  rsp.kind = KIND_DROPPED;
               end
            end else begin
               rsp.kind = KIND_UNMAPPED;
            end
         end
         OP_PAGE_READ: begin
            rsp.kind = KIND_REG_DATA;
            rsp.out_data = reg_ok ? page : '0;
         end
         default: begin
            rsp.kind = KIND_DONE;
         end
      endcase
      rsp.last = beat_ff == n_last;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_EMIT;
   assign rsp_word = rsp;

endmodule

### rtl/pmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_checker
// Port-level checks on the mapper's command sequencing, bound to the core.
// ----------------------------------------------------------------------------
module pmm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input pmm_pkg::rsp_type rsp_word
);
   import pmm_pkg::*;

   // An accepted word makes the block busy and gives no result in the lookup cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted word did not enter the lookup cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result word while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.last |=> !busy && !rsp_strobe)
      else $error("activity after the final result word");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.last |=> rsp_strobe)
      else $error("result sequence broken before its final word");

   a_single_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_word.kind == KIND_DONE || rsp_word.kind == KIND_REG_DATA
         || rsp_word.kind == KIND_RAM_READ || rsp_word.kind == KIND_ROM_READ)
      |-> rsp_word.last)
      else $error("single-word result not marked last");

endmodule

bind paged_memory_mapper_with_plane_writes_core pmm_checker u_pmm_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_strobe(rsp_strobe),
   .rsp_word(rsp_word)
);

### tb/sv/paged_memory_mapper_with_plane_writes_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_memory_mapper_with_plane_writes_core_tb
// Self-checking bench for the page mapper. A shadow copy of the page
// registers and the video mode predicts the memory commands of every accepted
// request word. Each response word is compared with the oldest prediction.
// Directed tests cover reset state, RAM, ROM, plane, copy-mode, unmapped and
// spare-operation paths, then random traffic runs with bursty request timing.
// ----------------------------------------------------------------------------
module paged_memory_mapper_with_plane_writes_core_tb;
   import pmm_pkg::*;

   localparam int WINDOW_COUNT = WINDOW_COUNT_DEFAULT;
   localparam int WINDOW_BITS = WINDOW_BITS_DEFAULT;
   localparam int OFFSET_MASK = (1 << WINDOW_BITS) - 1;
   localparam real CLOCK_PERIOD = 12.0;
   localparam int DRAIN_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;
   localparam logic [DATA_W-1:0] LOW_NIBBLE = 8'h0F;
   localparam logic [DATA_W-1:0] ROM_BANK_BIAS = 8'h08;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   logic [DATA_W-1:0] shadow_pages [WINDOW_COUNT];
   logic [MODE_W-1:0] shadow_mode;
   rsp_type           predicted_commands [$];
   int                error_count = 0;
   int                burst_left = 0;

   paged_memory_mapper_with_plane_writes_core #(
      .WINDOW_COUNT(WINDOW_COUNT),
      .WINDOW_BITS (WINDOW_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic rsp_type make_command(input kind_type kind,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] data);
      rsp_type cmd;
      cmd.kind = kind;
      cmd.target_address = addr;
      cmd.out_data = data;
      cmd.last = 1'b0;
      return cmd;
   endfunction

   // Applies one request word to the shadow state and queues its commands.
   function automatic void predict_commands(input req_type w);
      rsp_type              cmds [3];
      int                   n;
      int                   win;
      int                   plane;
      logic [REG_IDX_W-1:0] idx;
      logic [ADDR_W-1:0]    off;
      logic [ADDR_W-1:0]    part;
      logic [ADDR_W-1:0]    phys;
      logic [DATA_W-1:0]    page;
      logic [ADDR_W-1:0]    plane_base [3];
      plane_base = '{BASE_RED, BASE_GREEN, BASE_BLUE};
      idx = w.address[REG_IDX_W-1:0];
      n = 1;
      case (w.operation)
         OP_CPU_READ, OP_CPU_WRITE: begin
            win = int'(w.address) >> WINDOW_BITS;
            off = w.address & ADDR_W'(OFFSET_MASK);
            if (win >= WINDOW_COUNT) begin
               cmds[0] = make_command(KIND_UNMAPPED, '0, '0);
            end else begin
               page = shadow_pages[win];
               if (page >= RAM_FIRST && page <= RAM_LAST) begin
                  phys = (ADDR_W'(page & LOW_NIBBLE) << WINDOW_BITS) + off;
                  case ({page[DATA_W-1:1], 1'b0})
                     PLANE_RED:   plane = 0;
                     PLANE_GREEN: plane = 1;
                     PLANE_BLUE:  plane = 2;
                     default:     plane = -1;
                  endcase
                  part = page[0] ? PLANE_PART : '0;
                  if (w.operation == OP_CPU_READ) begin
                     cmds[0] = make_command(KIND_RAM_READ, phys, '0);
                  end else if (plane < 0) begin
                     cmds[0] = make_command(KIND_RAM_WRITE, phys, w.write_data);
                  end else if (shadow_mode[COPY_BIT]) begin
                     // Copy mode writes every plane: data where its mode bit is set.
                     for (int i = 0; i < 3; i++) begin
                        cmds[i] = make_command(KIND_RAM_WRITE, plane_base[i] + off + part,
                                               shadow_mode[i] ? w.write_data : '0);
                     end
                     n = 3;
                  end else begin
                     cmds[0] = make_command(KIND_RAM_WRITE, plane_base[plane] + off + part,
                                            w.write_data);
                  end
               end else if (page >= ROM_FIRST) begin
                  if (w.operation == OP_CPU_WRITE) begin
                     cmds[0] = make_command(KIND_DROPPED, '0, '0);
                  end else begin
                     phys = ((ADDR_W'(page & LOW_NIBBLE) - ADDR_W'(ROM_BANK_BIAS))
                             << WINDOW_BITS) + off;
                     cmds[0] = make_command(KIND_ROM_READ, phys, '0);
                  end
               end else begin
                  cmds[0] = make_command(KIND_UNMAPPED, '0, '0);
               end
            end
         end
         OP_PAGE_WRITE: begin
            if (int'(idx) < WINDOW_COUNT) shadow_pages[idx] = w.write_data;
            cmds[0] = make_command(KIND_DONE, '0, '0);
         end
         OP_PAGE_READ: begin
            cmds[0] = make_command(KIND_REG_DATA, '0,
                                   int'(idx) < WINDOW_COUNT ? shadow_pages[idx] : '0);
         end
         OP_MODE_WRITE: begin
            shadow_mode = w.write_data[MODE_W-1:0];
            cmds[0] = make_command(KIND_DONE, '0, '0);
         end
         default: begin
            cmds[0] = make_command(KIND_DONE, '0, '0);
         end
      endcase
      cmds[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) predicted_commands.push_back(cmds[i]);
   endfunction

   // Called at a falling edge; returns at a falling edge with start possibly
   // still high so that the next word follows back to back.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      req_type w;
      int      gap;
      w.operation = op;
      w.address = addr;
      w.write_data = data;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      predict_commands(w);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         burst_left = $urandom_range(0, 15);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      for (int c = 0; c < DRAIN_LIMIT && predicted_commands.size() != 0; c++) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] random_page_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return RAM_FIRST + DATA_W'($urandom_range(0, 15));
      if (pick < 55) return {PLANE_RED[DATA_W-1:4], 4'($urandom_range(0, 15))} | 8'h06;
      if (pick < 80) return ROM_FIRST + DATA_W'($urandom_range(0, 7));
      return DATA_W'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (predicted_commands.size() == 0) begin
            report_mismatch("response word with nothing expected", 32'(rsp_word), 0);
         end else begin
            want = predicted_commands.pop_front();
            if (rsp_word.kind !== want.kind)
               report_mismatch("kind", 32'(rsp_word.kind), 32'(want.kind));
            if (rsp_word.target_address !== want.target_address)
               report_mismatch("target_address", 32'(rsp_word.target_address),
                               32'(want.target_address));
            if (rsp_word.out_data !== want.out_data)
               report_mismatch("out_data", 32'(rsp_word.out_data), 32'(want.out_data));
            if (rsp_word.last !== want.last)
               report_mismatch("last", 32'(rsp_word.last), 32'(want.last));
         end
      end
   end

   task automatic test_reset_state();
      send_word(OP_PAGE_READ, 16'h0000, 8'h00);
      send_word(OP_PAGE_READ, 16'hFFFF, 8'hFF);
      send_word(OP_CPU_READ, 16'h0000, 8'h00);
      send_word(OP_CPU_WRITE, 16'hFFFF, 8'hA5);
   endtask

   task automatic test_ram_and_rom_pages();
      send_word(OP_PAGE_WRITE, 16'h0001, RAM_FIRST);
      send_word(OP_PAGE_WRITE, 16'hFFFE, 8'hE9);
      send_word(OP_PAGE_WRITE, 16'h000D, ROM_FIRST);
      send_word(OP_CPU_WRITE, 16'h1FFF, 8'hFF);
      send_word(OP_CPU_WRITE, 16'hEABC, 8'h00);
      send_word(OP_CPU_READ, 16'hD123, 8'h5A);
   endtask

   task automatic test_plane_writes();
      send_word(OP_PAGE_WRITE, 16'h0002, PLANE_RED);
      send_word(OP_PAGE_WRITE, 16'h0003, PLANE_GREEN | 8'h01);
      send_word(OP_PAGE_WRITE, 16'h0004, PLANE_BLUE | 8'h01);
      send_word(OP_CPU_WRITE, 16'h2000, 8'h55);
      send_word(OP_CPU_WRITE, 16'h3FFF, 8'hAA);
      send_word(OP_CPU_WRITE, 16'h4FFF, 8'h81);
      // A read of a plane page stays an ordinary RAM read.
      send_word(OP_CPU_READ, 16'h4010, 8'h00);
   endtask

   task automatic test_copy_mode();
      send_word(OP_MODE_WRITE, 16'h0000, 8'hFF);
      send_word(OP_CPU_WRITE, 16'h2001, 8'h3C);
      send_word(OP_MODE_WRITE, 16'hFFFF, 8'h08);
      send_word(OP_CPU_WRITE, 16'h4FFF, 8'hC3);
      // Copy bit clear with the upper bits set gives a single plane write.
      send_word(OP_MODE_WRITE, 16'h1234, 8'hF5);
      send_word(OP_CPU_WRITE, 16'h3800, 8'h7E);
   endtask

   task automatic test_unmapped_pages();
      send_word(OP_PAGE_WRITE, 16'h0005, 8'h00);
      send_word(OP_PAGE_WRITE, 16'h0006, 8'hF7);
      send_word(OP_CPU_READ, 16'h5000, 8'h00);
      send_word(OP_CPU_WRITE, 16'h6FFF, 8'h11);
   endtask

   task automatic test_spare_operations();
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         send_word(OP_W'(op), 16'h0003, 8'h00);
      end
      send_word(OP_PAGE_READ, 16'h0003, 8'h00);
   endtask

   task automatic test_random_traffic(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            send_word(OP_CPU_READ, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)));
         else if (pick < 65)
            send_word(OP_CPU_WRITE, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)));
         else if (pick < 80)
            send_word(OP_PAGE_WRITE, ADDR_W'($urandom_range(0, 65535)), random_page_value());
         else if (pick < 88)
            send_word(OP_PAGE_READ, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)));
         else if (pick < 95)
            send_word(OP_MODE_WRITE, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)));
         else
            send_word(OP_SPARE_FIRST + OP_W'($urandom_range(0, 2)),
                      ADDR_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 255)));
      end
   endtask

   // Keeps most windows on plane pages and copy mode on, so fan-out is common.
   task automatic test_random_plane_traffic(input int count);
      int                pick;
      logic [DATA_W-1:0] plane_page;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_word(OP_CPU_WRITE, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)));
         end else if (pick < 65) begin
            send_word(OP_CPU_READ, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            case ($urandom_range(0, 3))
               0:       plane_page = PLANE_RED;
               1:       plane_page = PLANE_GREEN;
               2:       plane_page = PLANE_BLUE;
               default: plane_page = random_page_value();
            endcase
            plane_page[0] = plane_page[0] | 1'($urandom_range(0, 1));
            send_word(OP_PAGE_WRITE, ADDR_W'($urandom_range(0, 65535)), plane_page);
         end else begin
            send_word(OP_MODE_WRITE, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255))
                      | ($urandom_range(0, 3) != 0 ? 8'h08 : 8'h00));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      foreach (shadow_pages[i]) shadow_pages[i] = PAGE_RESET;
      shadow_mode = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_ram_and_rom_pages();
      test_plane_writes();
      test_copy_mode();
      test_unmapped_pages();
      test_spare_operations();
      test_random_traffic(200);
      // Let the mapper run dry once before the plane-heavy traffic.
      wait_for_results();
      test_random_plane_traffic(200);
      wait_for_results();

      if (predicted_commands.size() != 0)
         report_mismatch("words still expected at end", predicted_commands.size(), 0);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
